// ----- hw/rtl/hbac_pkg.sv -----
package hbac_pkg;

   localparam int LIMIT_COUNT = 7;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] FUNC_DRIVE  = 2'd0;
   localparam logic [1:0] FUNC_SAMPLE = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;

   localparam logic [1:0] MODE_STOPPED    = 2'd0;
   localparam logic [1:0] MODE_EXTENDING  = 2'd1;
   localparam logic [1:0] MODE_RETRACTING = 2'd2;
   localparam logic [1:0] MODE_TRIPPED    = 2'd3;

   localparam logic KIND_DRIVE     = 1'b0;
   localparam logic KIND_TELEMETRY = 1'b1;

   localparam logic [2:0] REG_END_OF_TRAVEL = 3'd7;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         channel;
      logic [1:0]         action_code;
      logic [31:0]        duration_ms;
      logic signed [15:0] sample_current_ma;
      logic [14:0]        sample_voltage_mv;
   } item_type;

   typedef struct packed {
      logic       result_kind;
      logic [2:0] result_channel;
      logic [1:0] channel_mode;
      logic [14:0] report_voltage_mv;
      logic signed [15:0] report_current_ma;
      logic       last;
   } result_type;

endpackage

// ----- hw/rtl/hbac_front.sv -----
module hbac_front #(
   parameter int CH_COUNT = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  hbac_pkg::item_type req_item,
   output logic               queue_valid,
   output hbac_pkg::item_type queue_item,
   input  logic               queue_pop
);
   import hbac_pkg::*;

   localparam logic [2:0] CH_LIMIT = 3'(CH_COUNT);

   item_type   queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       keep;
   logic       push;

   // drop unknown functions and unusable channels here
   always_comb begin
      priority if (req_item.func == FUNC_TICK) begin
         keep = 1'b1;
      end else if (req_item.func == FUNC_DRIVE || req_item.func == FUNC_SAMPLE) begin
         keep = (req_item.channel < CH_LIMIT);
      end else begin
         keep = 1'b0;
      end
   end

   assign busy        = (count_ff == 2'(QUEUE_DEPTH));
   assign push        = start && !busy && keep;
   assign queue_valid = (count_ff != 2'd0);
   assign queue_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = queue_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(queue_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ----- hw/rtl/hbac_back.sv -----
module hbac_back #(
   parameter int CH_COUNT    = 7,
   parameter int TIMER_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_valid,
   input  hbac_pkg::item_type   queue_item,
   output logic                 queue_pop,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_write_data,
   output logic                 rsp_valid,
   output hbac_pkg::result_type rsp_result
);
   import hbac_pkg::*;

   localparam int IDX_W = (CH_COUNT > 1) ? $clog2(CH_COUNT) : 1;
   localparam int SUM_W = ((TIMER_WIDTH > 32) ? TIMER_WIDTH : 32) + 1;
   localparam logic STATE_IDLE  = 1'b0;
   localparam logic STATE_SWEEP = 1'b1;

   logic                   state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [1:0]             mode_ff  [CH_COUNT];
   logic [1:0]             mode_in  [CH_COUNT];
   logic                   armed_ff [CH_COUNT];
   logic                   armed_in [CH_COUNT];
   logic [TIMER_WIDTH-1:0] rem_ff   [CH_COUNT];
   logic [TIMER_WIDTH-1:0] rem_in   [CH_COUNT];
   logic [14:0]            limit_ff [LIMIT_COUNT];
   logic signed [15:0]     eot_ff;
   logic                   valid_ff, valid_in;
   result_type             result_ff, result_in;

   logic [IDX_W-1:0]       ch;
   logic [TIMER_WIDTH-1:0] base;
   logic [SUM_W-1:0]       sum;
   logic [1:0]             new_mode;
   logic                   later_expiry;

   assign ch = queue_item.channel[IDX_W-1:0];

   always_comb begin
      base = armed_ff[ch] ? rem_ff[ch] : '0;
      sum  = SUM_W'(base) + SUM_W'(queue_item.duration_ms);
   end

   // any expiry still ahead of the sweep position
   always_comb begin
      later_expiry = 1'b0;
      for (int j = 0; j < CH_COUNT; j++) begin
         if (IDX_W'(j) > idx_ff && armed_ff[j] && rem_ff[j][TIMER_WIDTH-1:1] == '0) begin
            later_expiry = 1'b1;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      mode_in   = mode_ff;
      armed_in  = armed_ff;
      rem_in    = rem_ff;
      valid_in  = 1'b0;
      result_in = result_ff;
      queue_pop = 1'b0;
      new_mode  = MODE_STOPPED;
      unique case (state_ff)
         STATE_IDLE: begin
            if (queue_valid) begin
               queue_pop = 1'b1;
               unique case (queue_item.func)
                  FUNC_DRIVE: begin
                     new_mode = queue_item.action_code[0] ? MODE_EXTENDING : MODE_RETRACTING;
                     if (queue_item.action_code[1]) begin
                        armed_in[ch] = 1'b1;
                        if (sum[SUM_W-1:TIMER_WIDTH] != '0) begin
                           rem_in[ch] = '1;
                        end else begin
                           rem_in[ch] = sum[TIMER_WIDTH-1:0];
                        end
                     end
                     mode_in[ch]                 = new_mode;
                     valid_in                    = 1'b1;
                     result_in.result_kind       = KIND_DRIVE;
                     result_in.result_channel    = queue_item.channel;
                     result_in.channel_mode      = new_mode;
                     result_in.report_voltage_mv = '0;
                     result_in.report_current_ma = '0;
                     result_in.last              = 1'b1;
                  end
                  FUNC_SAMPLE: begin
                     new_mode = mode_ff[ch];
                     if (queue_item.sample_current_ma > $signed({1'b0, limit_ff[ch]})) begin
                        new_mode     = MODE_TRIPPED;
                        armed_in[ch] = 1'b0;
                     end
                     if ((new_mode == MODE_EXTENDING || new_mode == MODE_RETRACTING) &&
                         queue_item.sample_current_ma < eot_ff) begin
                        new_mode     = MODE_STOPPED;
                        armed_in[ch] = 1'b0;
                     end
                     mode_in[ch]                 = new_mode;
                     valid_in                    = 1'b1;
                     result_in.result_kind       = KIND_TELEMETRY;
                     result_in.result_channel    = queue_item.channel;
                     result_in.channel_mode      = new_mode;
                     result_in.report_voltage_mv = queue_item.sample_voltage_mv;
                     result_in.report_current_ma = queue_item.sample_current_ma;
                     result_in.last              = 1'b1;
                  end
                  default: begin
                     state_in = STATE_SWEEP;
                     idx_in   = '0;
                  end
               endcase
            end
         end
         STATE_SWEEP: begin
            if (armed_ff[idx_ff]) begin
               if (rem_ff[idx_ff][TIMER_WIDTH-1:1] == '0) begin
                  mode_in[idx_ff]             = MODE_STOPPED;
                  armed_in[idx_ff]            = 1'b0;
                  valid_in                    = 1'b1;
                  result_in.result_kind       = KIND_DRIVE;
                  result_in.result_channel    = 3'(idx_ff);
                  result_in.channel_mode      = MODE_STOPPED;
                  result_in.report_voltage_mv = '0;
                  result_in.report_current_ma = '0;
                  result_in.last              = !later_expiry;
               end else begin
                  rem_in[idx_ff] = rem_ff[idx_ff] - TIMER_WIDTH'(1);
               end
            end
            if (idx_ff == IDX_W'(CH_COUNT - 1)) begin
               state_in = STATE_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         valid_ff <= 1'b0;
         for (int i = 0; i < CH_COUNT; i++) begin
            mode_ff[i]  <= MODE_STOPPED;
            armed_ff[i] <= 1'b0;
         end
         for (int i = 0; i < LIMIT_COUNT; i++) begin
            limit_ff[i] <= '1;
         end
         eot_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         mode_ff  <= mode_in;
         armed_ff <= armed_in;
         if (csr_write_enable) begin
            if (csr_index == REG_END_OF_TRAVEL) begin
               eot_ff <= csr_write_data;
            end else begin
               limit_ff[csr_index] <= csr_write_data[14:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      rem_ff    <= rem_in;
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ----- hw/rtl/hbridge_actuator_channel_controller.sv -----
// H-bridge actuator controller for up to seven channels.
// Input beat: pulse start with req_* fields while busy is low; func 0 is a
// drive command, 1 a current sample, 2 a one-millisecond tick.
// Beats with an unknown func or an unusable channel are dropped at once.
// Accepted beats go into a two-entry queue; the back end takes one at a time.
// Result beats appear on rsp_* for one cycle, marked by rsp_valid; the
// receiver cannot stall them. rsp_last marks the final result of a beat.
// A command or sample passes through its queue entry and then the result
// register when the back end is free. A tick leaves the queue and then
// sweeps the channels one per cycle, so it occupies the back end for the
// whole sweep and gives at most one expiry result per cycle; commands and
// samples need no sweep.
// busy is high only while the queue holds two beats.
// csr_* writes a register at once: index 0..6 channel trip limits, 7 the
// end-of-travel current; write only while the block is idle.
// Reset (synchronous): all channels stopped, timers disarmed, limits at
// full scale, end-of-travel current zero, queue empty.
module hbridge_actuator_channel_controller #(
   parameter int NUM_CHANNELS = 7,
   parameter int TIMER_WIDTH  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [2:0]         req_channel,
   input  logic [1:0]         req_action_code,
   input  logic [31:0]        req_duration_ms,
   input  logic signed [15:0] req_sample_current_ma,
   input  logic [14:0]        req_sample_voltage_mv,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   output logic               rsp_valid,
   output logic               rsp_result_kind,
   output logic [2:0]         rsp_result_channel,
   output logic               rsp_drive_high_side_a,
   output logic               rsp_drive_high_side_b,
   output logic [1:0]         rsp_channel_mode,
   output logic [14:0]        rsp_report_voltage_mv,
   output logic signed [15:0] rsp_report_current_ma,
   output logic               rsp_last
);
   import hbac_pkg::*;

   localparam int CH_COUNT = (NUM_CHANNELS < LIMIT_COUNT) ? NUM_CHANNELS : LIMIT_COUNT;

   item_type   req_item;
   item_type   queue_item;
   logic       queue_valid;
   logic       queue_pop;
   result_type rsp_result;

   always_comb begin
      req_item.func              = req_func;
      req_item.channel           = req_channel;
      req_item.action_code       = req_action_code;
      req_item.duration_ms       = req_duration_ms;
      req_item.sample_current_ma = req_sample_current_ma;
      req_item.sample_voltage_mv = req_sample_voltage_mv;
   end

   hbac_front #(
      .CH_COUNT (CH_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .queue_valid (queue_valid),
      .queue_item  (queue_item),
      .queue_pop   (queue_pop)
   );

   hbac_back #(
      .CH_COUNT    (CH_COUNT),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_valid      (queue_valid),
      .queue_item       (queue_item),
      .queue_pop        (queue_pop),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_result       (rsp_result)
   );

   assign rsp_result_kind       = rsp_result.result_kind;
   assign rsp_result_channel    = rsp_result.result_channel;
   assign rsp_drive_high_side_a = (rsp_result.channel_mode == MODE_EXTENDING);
   assign rsp_drive_high_side_b = (rsp_result.channel_mode == MODE_RETRACTING);
   assign rsp_channel_mode      = rsp_result.channel_mode;
   assign rsp_report_voltage_mv = rsp_result.report_voltage_mv;
   assign rsp_report_current_ma = rsp_result.report_current_ma;
   assign rsp_last              = rsp_result.last;

endmodule

// ----- sim/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hbac_pkg::*;

   localparam int CHANNELS = 7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_BEATS = 192;
   localparam int MAX_ERRORS_SHOWN = 200;
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

   typedef struct {
      logic               kind;
      logic [2:0]         channel;
      logic               side_a;
      logic               side_b;
      logic [1:0]         mode;
      logic [14:0]        voltage;
      logic signed [15:0] current;
      logic               last;
   } report_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_func = FUNC_DRIVE;
   logic [2:0]         req_channel = '0;
   logic [1:0]         req_action_code = '0;
   logic [31:0]        req_duration_ms = '0;
   logic signed [15:0] req_sample_current_ma = '0;
   logic [14:0]        req_sample_voltage_mv = '0;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_write_data = '0;
   logic               rsp_valid;
   logic               rsp_result_kind;
   logic [2:0]         rsp_result_channel;
   logic               rsp_drive_high_side_a;
   logic               rsp_drive_high_side_b;
   logic [1:0]         rsp_channel_mode;
   logic [14:0]        rsp_report_voltage_mv;
   logic signed [15:0] rsp_report_current_ma;
   logic               rsp_last;

   logic [1:0]         act_mode [CHANNELS];
   logic               timer_on [CHANNELS];
   logic [31:0]        timer_left [CHANNELS];
   logic [14:0]        trip_limit [CHANNELS];
   logic signed [15:0] travel_end_current;
   report_type         pending_reports [$];
   int                 mismatch_count = 0;
   bit                 back_to_back = 1'b0;

   hbridge_actuator_channel_controller dut (.*);

   always #10 clock = ~clock;

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   function automatic report_type actuator_report(logic kind, int ch, logic [14:0] volt,
                                                  logic signed [15:0] cur, logic fin);
      report_type r;
      r.kind = kind;
      r.channel = 3'(ch);
      r.side_a = (act_mode[ch] == MODE_EXTENDING);
      r.side_b = (act_mode[ch] == MODE_RETRACTING);
      r.mode = act_mode[ch];
      r.voltage = volt;
      r.current = cur;
      r.last = fin;
      return r;
   endfunction

   task automatic stop_actuator(int ch);
      act_mode[ch] = MODE_STOPPED;
      timer_on[ch] = 1'b0;
      timer_left[ch] = '0;
   endtask

   task automatic predict_actuators(item_type beat);
      int                 ch;
      int                 last_expiry;
      logic [32:0]        total;
      logic signed [15:0] cur;
      ch = int'(beat.channel);
      cur = beat.sample_current_ma;
      if (beat.func == FUNC_TICK) begin
         last_expiry = -1;
         for (int c = 0; c < CHANNELS; c++)
            if (timer_on[c] && timer_left[c] <= 32'd1) last_expiry = c;
         for (int c = 0; c < CHANNELS; c++) begin
            if (timer_on[c] && timer_left[c] <= 32'd1) begin
               stop_actuator(c);
               pending_reports.push_back(actuator_report(KIND_DRIVE, c, '0, '0,
                                                         c == last_expiry));
            end else if (timer_on[c]) begin
               timer_left[c] = timer_left[c] - 32'd1;
            end
         end
      end else if (beat.func == FUNC_DRIVE && ch < CHANNELS) begin
         act_mode[ch] = beat.action_code[0] ? MODE_EXTENDING : MODE_RETRACTING;
         if (beat.action_code[1]) begin
            total = {1'b0, (timer_on[ch] ? timer_left[ch] : 32'd0)} +
                    {1'b0, beat.duration_ms};
            timer_left[ch] = total[32] ? '1 : total[31:0];
            timer_on[ch] = 1'b1;
         end
         pending_reports.push_back(actuator_report(KIND_DRIVE, ch, '0, '0, 1'b1));
      end else if (beat.func == FUNC_SAMPLE && ch < CHANNELS) begin
         if (cur > $signed({1'b0, trip_limit[ch]})) begin
            stop_actuator(ch);
            act_mode[ch] = MODE_TRIPPED;
         end
         if ((act_mode[ch] == MODE_EXTENDING || act_mode[ch] == MODE_RETRACTING) &&
             cur < travel_end_current)
            stop_actuator(ch);
         pending_reports.push_back(actuator_report(KIND_TELEMETRY, ch,
                                                   beat.sample_voltage_mv, cur, 1'b1));
      end
   endtask

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_ERRORS_SHOWN)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(negedge clock) begin : check_results
      report_type want;
      if (!reset && rsp_valid) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_ERRORS_SHOWN)
               $error("unexpected result beat on channel %0d", rsp_result_channel);
         end else begin
            want = pending_reports.pop_front();
            compare_field("result_kind", want.kind, rsp_result_kind);
            compare_field("result_channel", want.channel, rsp_result_channel);
            compare_field("drive_high_side_a", want.side_a, rsp_drive_high_side_a);
            compare_field("drive_high_side_b", want.side_b, rsp_drive_high_side_b);
            compare_field("channel_mode", want.mode, rsp_channel_mode);
            compare_field("report_voltage_mv", want.voltage, rsp_report_voltage_mv);
            compare_field("report_current_ma", want.current, rsp_report_current_ma);
            compare_field("last", want.last, rsp_last);
         end
      end
   end

   function automatic int idle_gap();
      int roll;
      if (back_to_back) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic item_type make_beat(logic [1:0] func, int ch, int code,
                                          logic [31:0] dur, int cur, int volt);
      item_type b;
      b.func = func;
      b.channel = 3'(ch);
      b.action_code = 2'(code);
      b.duration_ms = dur;
      b.sample_current_ma = 16'(cur);
      b.sample_voltage_mv = 15'(volt);
      return b;
   endfunction

   // called just after a rising edge; returns after the accepting edge and the gap
   task automatic send_beat(item_type beat, int gap);
      logic ready;
      start <= 1'b1;
      req_func <= beat.func;
      req_channel <= beat.channel;
      req_action_code <= beat.action_code;
      req_duration_ms <= beat.duration_ms;
      req_sample_current_ma <= beat.sample_current_ma;
      req_sample_voltage_mv <= beat.sample_voltage_mv;
      do begin
         @(negedge clock);
         ready = !busy;
         if (ready) predict_actuators(beat);
         @(posedge clock);
      end while (!ready);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_until_idle();
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      if (index == REG_END_OF_TRAVEL) travel_end_current = value;
      else trip_limit[index] = value[14:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_timer_expiry_all_channels();
      for (int c = 0; c < CHANNELS; c++)
         send_beat(make_beat(FUNC_DRIVE, c, 2 + c % 2, 32'(c % 2), 0, 0), idle_gap());
      send_beat(make_beat(FUNC_TICK, 0, 0, '0, 0, 0), idle_gap());
   endtask

   task automatic test_timer_saturation();
      send_beat(make_beat(FUNC_DRIVE, 3, 3, 32'hFFFF_FFFF, 0, 0), idle_gap());
      send_beat(make_beat(FUNC_DRIVE, 3, 2, 32'd5, 0, 0), idle_gap());
      send_beat(make_beat(FUNC_TICK, 0, 0, '0, 0, 0), idle_gap());
   endtask

   task automatic test_drive_codes_and_dropped_beats();
      send_beat(make_beat(FUNC_DRIVE, 0, 0, $urandom, 0, 0), idle_gap());
      send_beat(make_beat(FUNC_DRIVE, 1, 1, $urandom, 0, 0), idle_gap());
      send_beat(make_beat(FUNC_DRIVE, 7, 1, 32'd3, 0, 0), idle_gap());
      send_beat(make_beat(FUNC_UNKNOWN, 5, 3, 32'd1, -1, 32767), idle_gap());
   endtask

   task automatic test_current_rules();
      wait_until_idle();
      write_register(3'd0, 16'd0);
      write_register(3'd6, 16'hFFFF);
      write_register(REG_END_OF_TRAVEL, 16'd100);
      send_beat(make_beat(FUNC_SAMPLE, 0, 0, '0, 1, 1234), idle_gap());
      send_beat(make_beat(FUNC_SAMPLE, 0, 0, '0, 0, 32767), idle_gap());
      send_beat(make_beat(FUNC_SAMPLE, 1, 0, '0, 50, 12000), idle_gap());
      send_beat(make_beat(FUNC_DRIVE, 6, 0, '0, 0, 0), idle_gap());
      send_beat(make_beat(FUNC_SAMPLE, 6, 0, '0, 32767, 32767), idle_gap());
      send_beat(make_beat(FUNC_SAMPLE, 5, 0, '0, -32768, 0), idle_gap());
      send_beat(make_beat(FUNC_SAMPLE, 7, 0, '0, 40000, 100), idle_gap());
      wait_until_idle();
      write_register(REG_END_OF_TRAVEL, 16'h8000);
      send_beat(make_beat(FUNC_DRIVE, 5, 0, '0, 0, 0), idle_gap());
      send_beat(make_beat(FUNC_SAMPLE, 5, 0, '0, -32768, 5000), idle_gap());
      wait_until_idle();
      write_register(REG_END_OF_TRAVEL, 16'h7FFF);
      send_beat(make_beat(FUNC_SAMPLE, 5, 0, '0, 32766, 24000), idle_gap());
   endtask

   function automatic item_type random_beat();
      item_type b;
      int       roll;
      int       ch;
      int       cur;
      roll = $urandom_range(0, 99);
      ch = $urandom_range(0, CHANNELS - 1);
      b = make_beat(FUNC_TICK, ch, $urandom_range(0, 3), $urandom, $urandom, $urandom);
      if (roll < 4) begin
         b.func = FUNC_UNKNOWN;
         b.channel = 3'($urandom);
      end else if (roll < 7) begin
         b.func = 2'($urandom_range(0, 1));
         b.channel = 3'd7;
      end else if (roll < 40) begin
         b.func = FUNC_DRIVE;
         case ($urandom_range(0, 9))
            0: b.duration_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            1: b.duration_ms = $urandom;
            2, 3: b.duration_ms = $urandom_range(0, 60);
            default: b.duration_ms = $urandom_range(0, 6);
         endcase
      end else if (roll >= 70) begin
         b.func = FUNC_SAMPLE;
         case ($urandom_range(0, 3))
            0: cur = int'(trip_limit[ch]) + $urandom_range(0, 2) - 1;
            1: cur = int'(travel_end_current) + $urandom_range(0, 2) - 1;
            2: cur = $urandom_range(0, 2000) - 1000;
            default: cur = $urandom;
         endcase
         b.sample_current_ma = 16'(cur);
      end
      return b;
   endfunction

   task automatic configure_phase(int phase);
      for (int c = 0; c < CHANNELS; c++) begin
         case (phase)
            0: write_register(3'(c), 16'($urandom));
            1: write_register(3'(c), 16'h0000);
            2: write_register(3'(c), 16'hFFFF);
            default: write_register(3'(c), 16'($urandom_range(0, 2000)));
         endcase
      end
      case (phase)
         0: write_register(REG_END_OF_TRAVEL, 16'($urandom));
         1: write_register(REG_END_OF_TRAVEL, 16'h8000);
         2: write_register(REG_END_OF_TRAVEL, 16'h7FFF);
         default: write_register(REG_END_OF_TRAVEL, 16'($urandom_range(0, 1000) - 500));
      endcase
   endtask

   task automatic test_random_traffic();
      item_type beat;
      int       counted;
      for (int phase = 0; phase < 4; phase++) begin
         wait_until_idle();
         configure_phase(phase);
         counted = 0;
         while (counted < RANDOM_BEATS / 4) begin
            // in phase 1, after 25 counted beats, the sender holds off until the block has answered everything
            if (phase == 1 && counted == 25) wait_until_idle();
            if ($urandom_range(0, 15) == 0) back_to_back = !back_to_back;
            beat = random_beat();
            if (beat.func != FUNC_UNKNOWN && beat.channel < CHANNELS) counted++;
            send_beat(beat, idle_gap());
         end
      end
      back_to_back = 1'b0;
   endtask

   initial begin
      for (int c = 0; c < CHANNELS; c++) begin
         act_mode[c] = MODE_STOPPED;
         timer_on[c] = 1'b0;
         timer_left[c] = '0;
         trip_limit[c] = 15'h7FFF;
      end
      travel_end_current = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_timer_expiry_all_channels();
      test_timer_saturation();
      test_drive_codes_and_dropped_beats();
      test_current_rules();
      test_random_traffic();
      wait_until_idle();
      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- hbridge_actuator_channel_controller.f -----
hw/rtl/hbac_pkg.sv
hw/rtl/hbac_front.sv
hw/rtl/hbac_back.sv
hw/rtl/hbridge_actuator_channel_controller.sv
sim/testbench.sv
